[design/shbg_pkg.sv]
// ----------------------------------------------------------------------------
// Sample history bar graph package
// Types and fixed constants shared by the bar graph unit, its channels and
// its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package shbg_pkg;

   // Field widths of the request and response items.
   localparam int KIND_W      = 1;
   localparam int TEMP_W      = 15;
   localparam int COLUMN_W    = 4;
   localparam int CODE_W      = 3;

   // Stored samples are saturated to 14-bit signed values.
   localparam int SAMPLE_W    = 14;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 14'sh1FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 14'sh2000;

   // Level arithmetic: the scaled numerator is at most 18 bits once positive.
   localparam int LEVEL_W     = 18;
   localparam int STEP_W      = $clog2(LEVEL_W);
   localparam int SPAN_SHIFT  = 4;        // sixteen levels across the range
   localparam int CELL_STEPS  = 8;
   localparam int TOP_CODE    = 7;
   localparam int FLAT_RANGE  = 100;      // one degree when the range is flat

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b0;
   localparam logic [KIND_W-1:0] KIND_RENDER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } shbg_state_type;

   typedef struct packed {
      logic req_ready;
      logic sample_wr;
      logic render_start;
      logic ram_rd_en;
      logic load_op;
      logic div_step;
      logic emit_cell;
   } shbg_ctrl_type;

endpackage

`default_nettype wire

[design/shbg_ifs.sv]
// ----------------------------------------------------------------------------
// Sample history bar graph channels
// Valid/ready channels for request items and for bar cell response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface shbg_req_if
   import shbg_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [TEMP_W-1:0] temperature;

   modport source (output valid, output kind, output temperature, input ready);
   modport sink   (input valid, input kind, input temperature, output ready);
endinterface

interface shbg_rsp_if
   import shbg_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [COLUMN_W-1:0] column;
   logic                row;
   logic [CODE_W-1:0]   char_code;
   logic                last;

   modport source (output valid, output column, output row, output char_code,
                   output last, input ready);
   modport sink   (input valid, input column, input row, input char_code,
                   input last, output ready);
endinterface

`default_nettype wire

[design/shbg_ram.sv]
// ----------------------------------------------------------------------------
// Sample history bar graph RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module shbg_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 60
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/sample_history_bar_graph_unit.sv]
// ----------------------------------------------------------------------------
// Sample history bar graph unit
// Temperature history ring with all-time extremes and a bar graph renderer.
// ----------------------------------------------------------------------------
// A sample item (kind 0) is taken in the same cycle that it is offered in
// the idle state: the temperature is saturated to 14 bits, written into the
// history ring at the write pointer, and folded into the all-time lowest and
// highest values; it yields no result. A render item (kind 1) walks COLUMNS
// columns, oldest sample first, and yields one to ROWS bar cell items per
// column, the final one flagged with last. Each column passes through a RAM
// read, a setup step, the bit-serial restoring divider when the scaled level
// is positive, and one emission step per cell; the response side can stall
// the emission. The divider produces one quotient bit a cycle. The request
// side is not ready while a render is in progress; it is ready again right
// after the last cell has been loaded into the output register, even while
// that cell still waits to be taken. History entries never written read as
// zero through per-entry valid bits that reset clears at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_history_bar_graph_unit
   import shbg_pkg::*;
#(
   parameter int HISTORY_DEPTH = 60,
   parameter int COLUMNS       = 16,
   parameter int ROWS          = 2
) (
   input wire logic  clock,
   input wire logic  reset,
   shbg_req_if.sink   req_chan,
   shbg_rsp_if.source rsp_chan
);

   localparam int PW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(COLUMNS + 1);
   localparam int RW = $clog2(ROWS + 1);

   // -------------------------------------------------------------------------
   // State.
   // -------------------------------------------------------------------------
   shbg_state_type state_ff, state_in;
   shbg_ctrl_type  ctrl;

   logic [PW-1:0]              wp_ff, wp_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in;
   logic signed [SAMPLE_W-1:0] hi_ff, hi_in;
   logic [HISTORY_DEPTH-1:0]   valid_ff, valid_in;
   logic [PW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic [CW-1:0]              col_ff, col_in;
   logic [RW-1:0]              row_ff, row_in;
   // The quotient register doubles as the dividend shifter and, once the
   // division is done, as the remaining level of the current column.
   logic [LEVEL_W-1:0]         quo_ff, quo_in;
   logic [SAMPLE_W-1:0]        rem_ff, rem_in;
   logic [SAMPLE_W-1:0]        dvsr_ff, dvsr_in;
   logic [STEP_W-1:0]          step_ff, step_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_W-1:0]        rsp_column_ff, rsp_column_in;
   logic                       rsp_row_ff, rsp_row_in;
   logic [CODE_W-1:0]          rsp_code_ff, rsp_code_in;
   logic                       rsp_last_ff, rsp_last_in;

   // -------------------------------------------------------------------------
   // Sample saturation. A 15-bit value is out of the 14-bit range exactly when
   // its two top bits differ.
   // -------------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] sat_sample;

   always_comb begin
      if (req_chan.temperature[TEMP_W-1] != req_chan.temperature[TEMP_W-2]) begin
         sat_sample = req_chan.temperature[TEMP_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         sat_sample = req_chan.temperature[SAMPLE_W-1:0];
      end
   end

   // -------------------------------------------------------------------------
   // History ring.
   // -------------------------------------------------------------------------
   logic [SAMPLE_W-1:0] ram_rd_data;

   shbg_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.sample_wr),
      .wr_addr (wp_ff),
      .wr_data (sat_sample),
      .rd_en   (ctrl.ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // -------------------------------------------------------------------------
   // Column setup. The numerator is (v - lowest) * 16 and the divisor is the
   // span between the extremes. Before any sample the span is negative, and
   // both operands are negated. A flat span counts as one degree.
   // -------------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0]   col_sample;
   logic signed [SAMPLE_W:0]     col_diff;
   logic signed [SAMPLE_W+4:0]   num_raw;
   logic signed [SAMPLE_W+4:0]   num_adj;
   logic signed [SAMPLE_W:0]     rng_raw;
   logic signed [SAMPLE_W:0]     rng_adj;
   logic                         num_pos;

   always_comb begin
      col_sample = rd_valid_ff ? ram_rd_data : '0;
      col_diff   = {col_sample[SAMPLE_W-1], col_sample} - {lo_ff[SAMPLE_W-1], lo_ff};
      num_raw    = {col_diff, {SPAN_SHIFT{1'b0}}};
      rng_raw    = {hi_ff[SAMPLE_W-1], hi_ff} - {lo_ff[SAMPLE_W-1], lo_ff};
      if (rng_raw == '0) begin
         num_adj = num_raw;
         rng_adj = (SAMPLE_W + 1)'(FLAT_RANGE);
      end else if (rng_raw[SAMPLE_W]) begin
         num_adj = -num_raw;
         rng_adj = -rng_raw;
      end else begin
         num_adj = num_raw;
         rng_adj = rng_raw;
      end
      num_pos = !num_adj[SAMPLE_W+4] && (num_adj != '0);
   end

   // -------------------------------------------------------------------------
   // Restoring divider step: one quotient bit per cycle.
   // -------------------------------------------------------------------------
   logic [SAMPLE_W:0] div_shift;
   logic [SAMPLE_W:0] div_trial;
   logic              div_ge;

   always_comb begin
      div_shift = {rem_ff, quo_ff[LEVEL_W-1]};
      div_trial = div_shift - {1'b0, dvsr_ff};
      div_ge    = (div_shift >= {1'b0, dvsr_ff});
   end

   // -------------------------------------------------------------------------
   // Cell emission. The bottom cell shows min(level, 7); each row up drops the
   // level by eight, and the column ends once the level would fall to zero or
   // the top row is reached.
   // -------------------------------------------------------------------------
   logic [CODE_W-1:0] cell_code;
   logic [RW-1:0]     cell_row;
   logic              col_done;
   logic              render_last;

   always_comb begin
      cell_code   = (quo_ff > LEVEL_W'(TOP_CODE)) ? CODE_W'(TOP_CODE)
                                                  : quo_ff[CODE_W-1:0];
      cell_row    = RW'(ROWS - 1) - row_ff;
      col_done    = (quo_ff <= LEVEL_W'(CELL_STEPS)) || (row_ff == RW'(ROWS - 1));
      render_last = col_done && (col_ff == CW'(COLUMNS - 1));
   end

   // -------------------------------------------------------------------------
   // Sequencer: next state.
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.render_start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = num_pos ? ST_DIV : ST_EMIT;
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (ctrl.emit_cell && col_done) begin
               state_in = render_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Sequencer: control outputs.
   // -------------------------------------------------------------------------
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready    = 1'b1;
            ctrl.sample_wr    = req_chan.valid && (req_chan.kind == KIND_SAMPLE);
            ctrl.render_start = req_chan.valid && (req_chan.kind == KIND_RENDER);
         end
         ST_READ: begin
            ctrl.ram_rd_en = 1'b1;
         end
         ST_LOAD: begin
            ctrl.load_op = 1'b1;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
         end
         ST_EMIT: begin
            ctrl.emit_cell = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Datapath next values.
   // -------------------------------------------------------------------------
   always_comb begin
      wp_in         = wp_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      valid_in      = valid_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_valid_in   = rd_valid_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dvsr_in       = dvsr_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_column_in = rsp_column_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_last_in   = rsp_last_ff;

      if (ctrl.sample_wr) begin
         valid_in[wp_ff] = 1'b1;
         wp_in = (wp_ff == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
         if (sat_sample < lo_ff) begin
            lo_in = sat_sample;
         end
         if (sat_sample > hi_ff) begin
            hi_in = sat_sample;
         end
      end

      if (ctrl.render_start) begin
         rd_ptr_in = wp_ff;
         col_in    = '0;
      end

      if (ctrl.ram_rd_en) begin
         rd_valid_in = valid_ff[rd_ptr_ff];
      end

      if (ctrl.load_op) begin
         quo_in  = num_pos ? num_adj[LEVEL_W-1:0] : '0;
         dvsr_in = rng_adj[SAMPLE_W-1:0];
         rem_in  = '0;
         step_in = STEP_W'(LEVEL_W - 1);
         row_in  = '0;
      end

      if (ctrl.div_step) begin
         rem_in  = div_ge ? div_trial[SAMPLE_W-1:0] : div_shift[SAMPLE_W-1:0];
         quo_in  = {quo_ff[LEVEL_W-2:0], div_ge};
         step_in = step_ff - STEP_W'(1);
      end

      if (ctrl.emit_cell) begin
         rsp_valid_in  = 1'b1;
         rsp_column_in = COLUMN_W'(col_ff);
         rsp_row_in    = cell_row[0];
         rsp_code_in   = cell_code;
         rsp_last_in   = render_last;
         if (!col_done) begin
            quo_in = quo_ff - LEVEL_W'(CELL_STEPS);
            row_in = row_ff + RW'(1);
         end else if (!render_last) begin
            col_in    = col_ff + CW'(1);
            rd_ptr_in = (rd_ptr_ff == PW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         lo_ff        <= SAMPLE_MAX;
         hi_ff        <= SAMPLE_MIN;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      rd_valid_ff   <= rd_valid_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dvsr_ff       <= dvsr_in;
      step_ff       <= step_in;
      rsp_column_ff <= rsp_column_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // -------------------------------------------------------------------------
   // Channel outputs.
   // -------------------------------------------------------------------------
   assign req_chan.ready     = ctrl.req_ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.column    = rsp_column_ff;
   assign rsp_chan.row       = rsp_row_ff;
   assign rsp_chan.char_code = rsp_code_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

`default_nettype wire

[design/shbg_checker.sv]
// ----------------------------------------------------------------------------
// Sample history bar graph checker
// Port-level assertions for the bar graph unit, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module shbg_checker
   import shbg_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [KIND_W-1:0]   req_kind,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [COLUMN_W-1:0] rsp_column,
   input wire logic                rsp_row,
   input wire logic [CODE_W-1:0]   rsp_char_code,
   input wire logic                rsp_last
);

   // A cell that is offered stays offered until it is taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // A stalled cell keeps its contents.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_column, rsp_row, rsp_char_code, rsp_last}))
      else $error("response payload changed while stalled");

   // An accepted render makes the unit busy on the next cycle.
   a_render_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_RENDER) |=> !req_ready)
      else $error("request side ready right after a render was accepted");

   // While a cell other than the final one is pending, the render is still
   // running and no new request can be taken.
   a_busy_mid_render : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request side ready in the middle of a render");

endmodule

bind sample_history_bar_graph_unit shbg_checker u_shbg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_kind      (req_chan.kind),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_column    (rsp_chan.column),
   .rsp_row       (rsp_chan.row),
   .rsp_char_code (rsp_chan.char_code),
   .rsp_last      (rsp_chan.last)
);

`default_nettype wire
